/* design/ucw_pkg.sv */
package ucw_pkg;

  // Widths of the code point and of the signed column count.
  localparam int CpWidth = 21;
  localparam int ColWidth = 3;

  // The non-spacing table is checked in parallel and reduced in groups.
  localparam int NsCount = 142;
  localparam int NsGroupSize = 8;
  localparam int NsGroups = (NsCount + NsGroupSize - 1) / NsGroupSize;

  typedef logic [CpWidth-1:0] cp_t;
  typedef logic signed [ColWidth-1:0] col_t;

  // Column width codes.
  localparam col_t W_CTRL = -3'sd1;
  localparam col_t W_ZERO = 3'sd0;
  localparam col_t W_ONE  = 3'sd1;
  localparam col_t W_TWO  = 3'sd2;

  // Classification flags handed from the compare stage to the select stage.
  typedef struct packed {
    logic                is_nul;
    logic                is_ctrl;
    logic                is_wide;
    logic [NsGroups-1:0] ns_grp;
  } ucw_flags_t;

  // Lower bounds of the non-spacing intervals, sorted.
  localparam cp_t NS_LO [NsCount] = '{
    21'h00300, 21'h00483, 21'h00488, 21'h00591, 21'h005BF, 21'h005C1, 21'h005C4,
    21'h005C7, 21'h00600, 21'h00610, 21'h0064B, 21'h00670, 21'h006D6, 21'h006E7,
    21'h006EA, 21'h0070F, 21'h00711, 21'h00730, 21'h007A6, 21'h007EB, 21'h00901,
    21'h0093C, 21'h00941, 21'h0094D, 21'h00951, 21'h00962, 21'h00981, 21'h009BC,
    21'h009C1, 21'h009CD, 21'h009E2, 21'h00A01, 21'h00A3C, 21'h00A41, 21'h00A47,
    21'h00A4B, 21'h00A70, 21'h00A81, 21'h00ABC, 21'h00AC1, 21'h00AC7, 21'h00ACD,
    21'h00AE2, 21'h00B01, 21'h00B3C, 21'h00B3F, 21'h00B41, 21'h00B4D, 21'h00B56,
    21'h00B82, 21'h00BC0, 21'h00BCD, 21'h00C3E, 21'h00C46, 21'h00C4A, 21'h00C55,
    21'h00CBC, 21'h00CBF, 21'h00CC6, 21'h00CCC, 21'h00CE2, 21'h00D41, 21'h00D4D,
    21'h00DCA, 21'h00DD2, 21'h00DD6, 21'h00E31, 21'h00E34, 21'h00E47, 21'h00EB1,
    21'h00EB4, 21'h00EBB, 21'h00EC8, 21'h00F18, 21'h00F35, 21'h00F37, 21'h00F39,
    21'h00F71, 21'h00F80, 21'h00F86, 21'h00F90, 21'h00F99, 21'h00FC6, 21'h0102D,
    21'h01032, 21'h01036, 21'h01039, 21'h01058, 21'h01160, 21'h0135F, 21'h01712,
    21'h01732, 21'h01752, 21'h01772, 21'h017B4, 21'h017B7, 21'h017C6, 21'h017C9,
    21'h017DD, 21'h0180B, 21'h018A9, 21'h01920, 21'h01927, 21'h01932, 21'h01939,
    21'h01A17, 21'h01B00, 21'h01B34, 21'h01B36, 21'h01B3C, 21'h01B42, 21'h01B6B,
    21'h01DC0, 21'h01DFE, 21'h0200B, 21'h0202A, 21'h02060, 21'h0206A, 21'h020D0,
    21'h0302A, 21'h03099, 21'h0A806, 21'h0A80B, 21'h0A825, 21'h0FB1E, 21'h0FE00,
    21'h0FE20, 21'h0FEFF, 21'h0FFF9, 21'h10A01, 21'h10A05, 21'h10A0C, 21'h10A38,
    21'h10A3F, 21'h1D167, 21'h1D173, 21'h1D185, 21'h1D1AA, 21'h1D242, 21'hE0001,
    21'hE0020, 21'hE0100
  };

  // Upper bounds of the non-spacing intervals, inclusive.
  localparam cp_t NS_HI [NsCount] = '{
    21'h0036F, 21'h00486, 21'h00489, 21'h005BD, 21'h005BF, 21'h005C2, 21'h005C5,
    21'h005C7, 21'h00603, 21'h00615, 21'h0065E, 21'h00670, 21'h006E4, 21'h006E8,
    21'h006ED, 21'h0070F, 21'h00711, 21'h0074A, 21'h007B0, 21'h007F3, 21'h00902,
    21'h0093C, 21'h00948, 21'h0094D, 21'h00954, 21'h00963, 21'h00981, 21'h009BC,
    21'h009C4, 21'h009CD, 21'h009E3, 21'h00A02, 21'h00A3C, 21'h00A42, 21'h00A48,
    21'h00A4D, 21'h00A71, 21'h00A82, 21'h00ABC, 21'h00AC5, 21'h00AC8, 21'h00ACD,
    21'h00AE3, 21'h00B01, 21'h00B3C, 21'h00B3F, 21'h00B43, 21'h00B4D, 21'h00B56,
    21'h00B82, 21'h00BC0, 21'h00BCD, 21'h00C40, 21'h00C48, 21'h00C4D, 21'h00C56,
    21'h00CBC, 21'h00CBF, 21'h00CC6, 21'h00CCD, 21'h00CE3, 21'h00D43, 21'h00D4D,
    21'h00DCA, 21'h00DD4, 21'h00DD6, 21'h00E31, 21'h00E3A, 21'h00E4E, 21'h00EB1,
    21'h00EB9, 21'h00EBC, 21'h00ECD, 21'h00F19, 21'h00F35, 21'h00F37, 21'h00F39,
    21'h00F7E, 21'h00F84, 21'h00F87, 21'h00F97, 21'h00FBC, 21'h00FC6, 21'h01030,
    21'h01032, 21'h01037, 21'h01039, 21'h01059, 21'h011FF, 21'h0135F, 21'h01714,
    21'h01734, 21'h01753, 21'h01773, 21'h017B5, 21'h017BD, 21'h017C6, 21'h017D3,
    21'h017DD, 21'h0180D, 21'h018A9, 21'h01922, 21'h01928, 21'h01932, 21'h0193B,
    21'h01A18, 21'h01B03, 21'h01B34, 21'h01B3A, 21'h01B3C, 21'h01B42, 21'h01B73,
    21'h01DCA, 21'h01DFF, 21'h0200F, 21'h0202E, 21'h02063, 21'h0206F, 21'h020EF,
    21'h0302F, 21'h0309A, 21'h0A806, 21'h0A80B, 21'h0A826, 21'h0FB1E, 21'h0FE0F,
    21'h0FE23, 21'h0FEFF, 21'h0FFFB, 21'h10A03, 21'h10A06, 21'h10A0F, 21'h10A3A,
    21'h10A3F, 21'h1D169, 21'h1D182, 21'h1D18B, 21'h1D1AD, 21'h1D244, 21'hE0001,
    21'hE007F, 21'hE01EF
  };

endpackage

/* design/ucw_match.sv */
module ucw_match (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  ucw_pkg::cp_t        in_cp,
  output logic                valid_r,
  output ucw_pkg::ucw_flags_t flags_r
);

  logic [ucw_pkg::NsCount-1:0] hit;
  ucw_pkg::ucw_flags_t         flags_nxt;
  logic                        valid_nxt;

  // Every non-spacing interval is checked against the word at once.
  always_comb begin
    for (int k = 0; k < ucw_pkg::NsCount; k++) begin
      hit[k] = (in_cp >= ucw_pkg::NS_LO[k]) && (in_cp <= ucw_pkg::NS_HI[k]);
    end
  end

  // Hits are folded into groups here; the last fold happens in the next stage.
  always_comb begin
    flags_nxt = '0;
    for (int g = 0; g < ucw_pkg::NsGroups; g++) begin
      for (int j = 0; j < ucw_pkg::NsGroupSize; j++) begin
        if (g * ucw_pkg::NsGroupSize + j < ucw_pkg::NsCount) begin
          flags_nxt.ns_grp[g] = flags_nxt.ns_grp[g] | hit[g * ucw_pkg::NsGroupSize + j];
        end
      end
    end

    flags_nxt.is_nul  = (in_cp == '0);
    flags_nxt.is_ctrl = ((in_cp != '0) && (in_cp < 21'h00020)) ||
                        ((in_cp >= 21'h0007F) && (in_cp < 21'h000A0));

    // East Asian wide and full-width ranges, with U+303F left narrow.
    flags_nxt.is_wide = ((in_cp >= 21'h01100) && (in_cp <= 21'h0115F)) ||
                        (in_cp == 21'h02329) || (in_cp == 21'h0232A) ||
                        ((in_cp >= 21'h02E80) && (in_cp <= 21'h0A4CF) &&
                         (in_cp != 21'h0303F)) ||
                        ((in_cp >= 21'h0AC00) && (in_cp <= 21'h0D7A3)) ||
                        ((in_cp >= 21'h0F900) && (in_cp <= 21'h0FAFF)) ||
                        ((in_cp >= 21'h0FE10) && (in_cp <= 21'h0FE19)) ||
                        ((in_cp >= 21'h0FE30) && (in_cp <= 21'h0FE6F)) ||
                        ((in_cp >= 21'h0FF00) && (in_cp <= 21'h0FF60)) ||
                        ((in_cp >= 21'h0FFE0) && (in_cp <= 21'h0FFE6)) ||
                        ((in_cp >= 21'h20000) && (in_cp <= 21'h2FFFD)) ||
                        ((in_cp >= 21'h30000) && (in_cp <= 21'h3FFFD));
  end

  assign valid_nxt = in_valid;

  // Stage register; only the valid bit is reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    flags_r <= flags_nxt;
  end

endmodule

/* design/ucw_select.sv */
module ucw_select (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  ucw_pkg::ucw_flags_t in_flags,
  output logic                valid_r,
  output ucw_pkg::col_t       width_r
);

  ucw_pkg::col_t width_nxt;
  logic          valid_nxt;

  // Priority order: NUL, controls, non-spacing, wide, then normal.
  always_comb begin
    if (in_flags.is_nul) begin
      width_nxt = ucw_pkg::W_ZERO;
    end else if (in_flags.is_ctrl) begin
      width_nxt = ucw_pkg::W_CTRL;
    end else if (|in_flags.ns_grp) begin
      width_nxt = ucw_pkg::W_ZERO;
    end else if (in_flags.is_wide) begin
      width_nxt = ucw_pkg::W_TWO;
    end else begin
      width_nxt = ucw_pkg::W_ONE;
    end
  end

  assign valid_nxt = in_valid;

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    width_r <= width_nxt;
  end

endmodule

/* design/unicode_column_width.sv */
// Terminal column width of one Unicode code point. A word is taken at every
// rising edge where start is high; busy never rises, so one code point can
// enter in every cycle. Its width appears on out_column_width (signed: -1
// control, 0 non-spacing, 1 normal, 2 wide) with out_valid high for exactly
// one cycle, once the word has passed the stage registers, and in input order.
// The receiver cannot stall the block: it must take each result in the cycle
// it is shown. The three stages are an input register, the parallel bank of
// interval comparators with a first level of OR folding, and the final
// select into the output register; the comparator bank sets the clock rate.
module unicode_column_width (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [20:0]                in_code_point,
  output logic                       out_valid,
  output logic signed [2:0]          out_column_width
);

  logic                valid_r;
  logic                valid_nxt;
  ucw_pkg::cp_t        cp_r;
  ucw_pkg::cp_t        cp_nxt;
  logic                match_valid;
  ucw_pkg::ucw_flags_t match_flags;
  ucw_pkg::col_t       sel_width;

  // The pipeline never holds back, so the block is never busy.
  assign busy = 1'b0;

  assign valid_nxt = start && !busy;
  assign cp_nxt    = in_code_point;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    cp_r <= cp_nxt;
  end

  ucw_match u_match (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (valid_r),
    .in_cp    (cp_r),
    .valid_r  (match_valid),
    .flags_r  (match_flags)
  );

  ucw_select u_select (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (match_valid),
    .in_flags (match_flags),
    .valid_r  (out_valid),
    .width_r  (sel_width)
  );

  assign out_column_width = sel_width;

`ifndef SYNTH
  // Every accepted word yields a result after the input, compare and select registers.
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("accepted word produced no result");

  // No result appears without a word accepted at the input register.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 3))
    else $error("result without an accepted word");

  // NUL measures zero columns, checked end to end through the stages.
  a_nul_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($past(in_code_point, 3) == 21'h0)) |->
      (out_column_width == ucw_pkg::W_ZERO))
    else $error("NUL did not give zero width");
`endif

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int RunLimit = 100000;
  localparam int DirectedCount = 25;

  // Inclusive intervals of code points that take no column.
  localparam int unsigned ZwSpans [142][2] = '{
    '{'h00300, 'h0036F}, '{'h00483, 'h00486}, '{'h00488, 'h00489}, '{'h00591, 'h005BD},
    '{'h005BF, 'h005BF}, '{'h005C1, 'h005C2}, '{'h005C4, 'h005C5}, '{'h005C7, 'h005C7},
    '{'h00600, 'h00603}, '{'h00610, 'h00615}, '{'h0064B, 'h0065E}, '{'h00670, 'h00670},
    '{'h006D6, 'h006E4}, '{'h006E7, 'h006E8}, '{'h006EA, 'h006ED}, '{'h0070F, 'h0070F},
    '{'h00711, 'h00711}, '{'h00730, 'h0074A}, '{'h007A6, 'h007B0}, '{'h007EB, 'h007F3},
    '{'h00901, 'h00902}, '{'h0093C, 'h0093C}, '{'h00941, 'h00948}, '{'h0094D, 'h0094D},
    '{'h00951, 'h00954}, '{'h00962, 'h00963}, '{'h00981, 'h00981}, '{'h009BC, 'h009BC},
    '{'h009C1, 'h009C4}, '{'h009CD, 'h009CD}, '{'h009E2, 'h009E3}, '{'h00A01, 'h00A02},
    '{'h00A3C, 'h00A3C}, '{'h00A41, 'h00A42}, '{'h00A47, 'h00A48}, '{'h00A4B, 'h00A4D},
    '{'h00A70, 'h00A71}, '{'h00A81, 'h00A82}, '{'h00ABC, 'h00ABC}, '{'h00AC1, 'h00AC5},
    '{'h00AC7, 'h00AC8}, '{'h00ACD, 'h00ACD}, '{'h00AE2, 'h00AE3}, '{'h00B01, 'h00B01},
    '{'h00B3C, 'h00B3C}, '{'h00B3F, 'h00B3F}, '{'h00B41, 'h00B43}, '{'h00B4D, 'h00B4D},
    '{'h00B56, 'h00B56}, '{'h00B82, 'h00B82}, '{'h00BC0, 'h00BC0}, '{'h00BCD, 'h00BCD},
    '{'h00C3E, 'h00C40}, '{'h00C46, 'h00C48}, '{'h00C4A, 'h00C4D}, '{'h00C55, 'h00C56},
    '{'h00CBC, 'h00CBC}, '{'h00CBF, 'h00CBF}, '{'h00CC6, 'h00CC6}, '{'h00CCC, 'h00CCD},
    '{'h00CE2, 'h00CE3}, '{'h00D41, 'h00D43}, '{'h00D4D, 'h00D4D}, '{'h00DCA, 'h00DCA},
    '{'h00DD2, 'h00DD4}, '{'h00DD6, 'h00DD6}, '{'h00E31, 'h00E31}, '{'h00E34, 'h00E3A},
    '{'h00E47, 'h00E4E}, '{'h00EB1, 'h00EB1}, '{'h00EB4, 'h00EB9}, '{'h00EBB, 'h00EBC},
    '{'h00EC8, 'h00ECD}, '{'h00F18, 'h00F19}, '{'h00F35, 'h00F35}, '{'h00F37, 'h00F37},
    '{'h00F39, 'h00F39}, '{'h00F71, 'h00F7E}, '{'h00F80, 'h00F84}, '{'h00F86, 'h00F87},
    '{'h00F90, 'h00F97}, '{'h00F99, 'h00FBC}, '{'h00FC6, 'h00FC6}, '{'h0102D, 'h01030},
    '{'h01032, 'h01032}, '{'h01036, 'h01037}, '{'h01039, 'h01039}, '{'h01058, 'h01059},
    '{'h01160, 'h011FF}, '{'h0135F, 'h0135F}, '{'h01712, 'h01714}, '{'h01732, 'h01734},
    '{'h01752, 'h01753}, '{'h01772, 'h01773}, '{'h017B4, 'h017B5}, '{'h017B7, 'h017BD},
    '{'h017C6, 'h017C6}, '{'h017C9, 'h017D3}, '{'h017DD, 'h017DD}, '{'h0180B, 'h0180D},
    '{'h018A9, 'h018A9}, '{'h01920, 'h01922}, '{'h01927, 'h01928}, '{'h01932, 'h01932},
    '{'h01939, 'h0193B}, '{'h01A17, 'h01A18}, '{'h01B00, 'h01B03}, '{'h01B34, 'h01B34},
    '{'h01B36, 'h01B3A}, '{'h01B3C, 'h01B3C}, '{'h01B42, 'h01B42}, '{'h01B6B, 'h01B73},
    '{'h01DC0, 'h01DCA}, '{'h01DFE, 'h01DFF}, '{'h0200B, 'h0200F}, '{'h0202A, 'h0202E},
    '{'h02060, 'h02063}, '{'h0206A, 'h0206F}, '{'h020D0, 'h020EF}, '{'h0302A, 'h0302F},
    '{'h03099, 'h0309A}, '{'h0A806, 'h0A806}, '{'h0A80B, 'h0A80B}, '{'h0A825, 'h0A826},
    '{'h0FB1E, 'h0FB1E}, '{'h0FE00, 'h0FE0F}, '{'h0FE20, 'h0FE23}, '{'h0FEFF, 'h0FEFF},
    '{'h0FFF9, 'h0FFFB}, '{'h10A01, 'h10A03}, '{'h10A05, 'h10A06}, '{'h10A0C, 'h10A0F},
    '{'h10A38, 'h10A3A}, '{'h10A3F, 'h10A3F}, '{'h1D167, 'h1D169}, '{'h1D173, 'h1D182},
    '{'h1D185, 'h1D18B}, '{'h1D1AA, 'h1D1AD}, '{'h1D242, 'h1D244}, '{'hE0001, 'hE0001},
    '{'hE0020, 'hE007F}, '{'hE0100, 'hE01EF}
  };

  // Control and wide range boundaries that random code points cluster around.
  localparam int unsigned BoundaryPoints [27] = '{
    'h00020, 'h0007F, 'h000A0, 'h01100, 'h0115F, 'h02329, 'h0232A, 'h02E80, 'h0303F,
    'h0A4CF, 'h0AC00, 'h0D7A3, 'h0F900, 'h0FAFF, 'h0FE10, 'h0FE19, 'h0FE30, 'h0FE6F,
    'h0FF00, 'h0FF60, 'h0FFE0, 'h0FFE6, 'h20000, 'h2FFFD, 'h30000, 'h3FFFD, 'h10FFFF
  };

  // Special and extreme code points sent before the random traffic.
  localparam int unsigned DirectedPoints [DirectedCount] = '{
    'h000000, 'h000001, 'h00001F, 'h000020, 'h00007E, 'h00007F, 'h00009F, 'h0000A0,
    'h0000AD, 'h000300, 'h00036F, 'h000370, 'h0010FF, 'h001100, 'h00115F, 'h001160,
    'h0011FF, 'h002329, 'h00303E, 'h00303F, 'h00D800, 'h00FFFE, 'h03FFFD, 'h10FFFF,
    'h1FFFFF
  };

  // Tracks the column widths still owed by the block, oldest first.
  class width_board;
    ucw_pkg::col_t owed_widths[$];
    int            mismatches;
    int            ctrl_seen, zero_seen, one_seen, two_seen;

    function new();
      mismatches = 0;
      ctrl_seen = 0;
      zero_seen = 0;
      one_seen = 0;
      two_seen = 0;
    endfunction

    function ucw_pkg::col_t width_of(ucw_pkg::cp_t cp);
      int unsigned c;
      bit          zero_width;
      bit          wide;
      c = cp;
      zero_width = 1'b0;
      for (int k = 0; k < 142; k++) begin
        if (c >= ZwSpans[k][0] && c <= ZwSpans[k][1]) zero_width = 1'b1;
      end
      wide = (c >= 'h1100) &&
             (c <= 'h115F || c == 'h2329 || c == 'h232A ||
              (c >= 'h2E80 && c <= 'hA4CF && c != 'h303F) ||
              (c >= 'hAC00 && c <= 'hD7A3) || (c >= 'hF900 && c <= 'hFAFF) ||
              (c >= 'hFE10 && c <= 'hFE19) || (c >= 'hFE30 && c <= 'hFE6F) ||
              (c >= 'hFF00 && c <= 'hFF60) || (c >= 'hFFE0 && c <= 'hFFE6) ||
              (c >= 'h20000 && c <= 'h2FFFD) || (c >= 'h30000 && c <= 'h3FFFD));
      if (c == 0) return ucw_pkg::W_ZERO;
      if (c < 'h20 || (c >= 'h7F && c < 'hA0)) return ucw_pkg::W_CTRL;
      if (zero_width) return ucw_pkg::W_ZERO;
      if (wide) return ucw_pkg::W_TWO;
      return ucw_pkg::W_ONE;
    endfunction

    // Called for every word the block takes.
    function void note_word(ucw_pkg::cp_t cp);
      ucw_pkg::col_t w;
      w = width_of(cp);
      owed_widths.push_back(w);
      case (w)
        ucw_pkg::W_CTRL: ctrl_seen++;
        ucw_pkg::W_ZERO: zero_seen++;
        ucw_pkg::W_TWO:  two_seen++;
        default:         one_seen++;
      endcase
    endfunction

    // Called for every result the block shows.
    function void check_width(ucw_pkg::col_t got);
      ucw_pkg::col_t want;
      if (owed_widths.size() == 0) begin
        $error("column_width: result with no word pending, expected none, actual %0d", got);
        mismatches++;
      end else begin
        want = owed_widths.pop_front();
        if (got !== want) begin
          $error("column_width: expected %0d, actual %0d", want, got);
          mismatches++;
        end
      end
    endfunction

    function int outstanding();
      return owed_widths.size();
    endfunction
  endclass

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  ucw_pkg::cp_t  in_code_point;
  logic          out_valid;
  ucw_pkg::col_t out_column_width;
  int            cycle_count;
  width_board    board = new();

  unicode_column_width u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_code_point    (in_code_point),
    .out_valid        (out_valid),
    .out_column_width (out_column_width)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a stuck handshake or a lost result ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < RunLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Sample both channels at the edge, before the drivers' updates land.
  always @(posedge clk) begin
    if (rst_n && start && !busy) board.note_word(in_code_point);
    if (rst_n && out_valid) board.check_width(out_column_width);
  end

  // Random code point, half the time close to the interesting range boundaries.
  function automatic ucw_pkg::cp_t pick_code_point();
    int unsigned pick;
    int unsigned base;
    pick = $urandom_range(99);
    if (pick < 35) begin
      base = ZwSpans[$urandom_range(141)][$urandom_range(1)];
      return ucw_pkg::cp_t'(base + $urandom_range(2) - 1);
    end else if (pick < 50) begin
      base = BoundaryPoints[$urandom_range(26)];
      return ucw_pkg::cp_t'(base + $urandom_range(2) - 1);
    end else if (pick < 70) begin
      return ucw_pkg::cp_t'($urandom_range('h2FFF));
    end else if (pick < 85) begin
      return ucw_pkg::cp_t'($urandom_range('h3FFFF));
    end
    return ucw_pkg::cp_t'($urandom);
  endfunction

  // Offer one word, idling first at the given rate, and hold it until taken.
  task automatic send_word(ucw_pkg::cp_t cp, int idle_pct);
    bit taken;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      in_code_point <= ucw_pkg::cp_t'($urandom);
      @(posedge clk);
    end
    start <= 1'b1;
    in_code_point <= cp;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
  endtask

  // Stop sending and let every owed result come back.
  task automatic wait_drained();
    start <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic send_random(int count, int idle_pct);
    for (int n = 0; n < count; n++) send_word(pick_code_point(), idle_pct);
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_code_point <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words, back to back.
    for (int n = 0; n < DirectedCount; n++) begin
      send_word(ucw_pkg::cp_t'(DirectedPoints[n]), 0);
    end
    wait_drained();

    // Sender idles rarely, often, then not at all.
    send_random(600, 10);
    wait_drained();
    send_random(600, 63);
    wait_drained();
    send_random(650, 0);
    wait_drained();

    $display("Covered %0d code points under three sender pacings, drained between phases.",
             board.ctrl_seen + board.zero_seen + board.one_seen + board.two_seen);
    $display("Widths seen: %0d control, %0d zero, %0d normal, %0d wide.",
             board.ctrl_seen, board.zero_seen, board.one_seen, board.two_seen);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
